// File: rtl/differential_thrust_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the differential thrust allocator
// Implication checks on the aclk domain, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_THRUST_ALLOCATOR_CORE_ASSERT_SVH
`define DIFFERENTIAL_THRUST_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define DTA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dta_pkg.sv
// ----------------------------------------------------------------------------
// dta_pkg
// Widths, codes and polynomial coefficients of the thrust allocator.
// ----------------------------------------------------------------------------
package dta_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COEF_SHIFT = 24 - FRAC_BITS;
    localparam int DATA_W     = 18;
    localparam int YMAX_W     = 17;
    localparam int PWM_W      = 11;
    localparam int ZONE_W     = 2;
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int RND_W      = 32;
    localparam int ACC_W      = 40;
    localparam int TW         = ACC_W + 2;
    localparam int STEP_W     = 4;

    localparam int PWM_NEUTRAL = 1500;
    localparam int PWM_LOW     = 1100;
    localparam int PWM_HIGH    = 1900;

    localparam logic [STEP_W-1:0] N_TERM_OPS = 4'd3;
    localparam logic [STEP_W-1:0] N_POLY_OPS = 4'd10;

    // zone codes
    localparam logic [ZONE_W-1:0] ZONE_FWD = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_REV = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_MIR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SURGE_MAX_FWD = 3'd0;
    localparam logic [2:0] CFG_SURGE_FWD_THR = 3'd1;
    localparam logic [2:0] CFG_SURGE_MIN_REV = 3'd2;
    localparam logic [2:0] CFG_YAW_REV_THR   = 3'd3;
    localparam logic [2:0] CFG_YAW_MAX_ABS   = 3'd4;
    localparam logic [2:0] CFG_DZ_POS        = 3'd5;
    localparam logic [2:0] CFG_DZ_NEG        = 3'd6;

    // configuration reset values
    localparam logic signed [DATA_W-1:0] RST_SURGE_MAX_FWD = 18'sd11662;
    localparam logic signed [DATA_W-1:0] RST_SURGE_FWD_THR = 18'sd5831;
    localparam logic signed [DATA_W-1:0] RST_SURGE_MIN_REV = -18'sd4804;
    localparam logic signed [DATA_W-1:0] RST_YAW_REV_THR   = 18'sd9259;
    localparam logic [YMAX_W-1:0]        RST_YAW_MAX_ABS   = 17'd15006;
    localparam logic signed [DATA_W-1:0] RST_DZ_POS        = 18'sd4915;
    localparam logic signed [DATA_W-1:0] RST_DZ_NEG        = -18'sd5243;

    // polynomial term indexes: 1, u, r, u*u, u*r, r*r
    localparam logic [2:0] TERM_ONE = 3'd0;
    localparam logic [2:0] TERM_U   = 3'd1;
    localparam logic [2:0] TERM_R   = 3'd2;
    localparam logic [2:0] TERM_UU  = 3'd3;
    localparam logic [2:0] TERM_UR  = 3'd4;
    localparam logic [2:0] TERM_RR  = 3'd5;
    localparam logic [2:0] N_TERMS  = 3'd6;

    // coefficients in Q.24
    localparam longint FWD_M_Q24 [6] = '{22725, 102302430, 0, -46456111, 0, -18418028};
    localparam longint FWD_D_Q24 [6] = '{0, 0, 106838989, 0, 138073132, 0};
    localparam longint REV_M_Q24 [6] = '{-100425, 103664740, 3371382, -86010076,
                                         17582522, -42422868};
    localparam longint REV_D_Q24 [6] = '{512510, -47214441, 90068484, 456961032,
                                         71620257, 232884535};
    localparam longint COEF_HALF = longint'(1) <<< (COEF_SHIFT - 1);

    // Coefficient rounded half up from Q.24 to FRAC_BITS.
    function automatic logic signed [MUL_W-1:0] coef_q(input logic rev, input logic is_d,
                                                       input logic [2:0] idx);
        longint c24;
        longint rnd;
        c24 = 0;
        if (idx < N_TERMS) begin
            case ({rev, is_d})
                2'b00:   c24 = FWD_M_Q24[idx];
                2'b01:   c24 = FWD_D_Q24[idx];
                2'b10:   c24 = REV_M_Q24[idx];
                2'b11:   c24 = REV_D_Q24[idx];
                default: c24 = 0;
            endcase
        end
        rnd = (c24 + COEF_HALF) >>> COEF_SHIFT;
        return MUL_W'(rnd);
    endfunction

endpackage

// File: rtl/dta_mul_round.sv
// ----------------------------------------------------------------------------
// dta_mul_round
// Shared signed multiplier with registered product and half-up rounding.
// ----------------------------------------------------------------------------
module dta_mul_round import dta_pkg::*; (
    input  logic                    aclk,
    input  logic signed [MUL_W-1:0] op_a,
    input  logic signed [MUL_W-1:0] op_b,
    output logic signed [RND_W-1:0] result
);

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    // round half up, then floor by the fraction width
    always_comb begin
        rnd    = (prod_reg + HALF) >>> FRAC_BITS;
        result = rnd[RND_W-1:0];
    end

endmodule

// File: rtl/differential_thrust_allocator_core.sv
// ----------------------------------------------------------------------------
// differential_thrust_allocator_core
// Turns surge and yaw demands into left and right thruster pulse widths.
// ----------------------------------------------------------------------------
// Sequence: a computed tick runs the clamp, the term products, one polynomial pass (two
//   when the forward model is checked and falls back to a reverse zone) and the pulse
//   widths before m_tvalid rises; warm-up ticks go straight to the output stage, and a
//   disarmed beat is taken with no output.
// Flow: one beat at a time, s_tready low until the tick leaves ST_OUT; the single shared
//   multiplier runs 3 term products and 10 (or 20) coefficient products per tick.
// Reset: aresetn (synchronous) clears the sequencer, warm-up count, output valid
//   and loads the configuration registers with their default limits.
// ----------------------------------------------------------------------------
`include "differential_thrust_allocator_core_assert.svh"

module differential_thrust_allocator_core import dta_pkg::*; #(
    parameter int WARMUP_TICKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [17:0] surge_demand, [35:18] yaw_demand, [39:36] zero
    input  logic [0:0]  s_tuser,    // [0] armed
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [10:0] left_pulse, [21:11] right_pulse,
                                    // [39:22] surge_applied, [57:40] yaw_applied, [63:58] zero
    output logic [1:0]  m_tuser,    // [1:0] zone_used
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_wdata
);

    localparam int WCW = (WARMUP_TICKS < 1) ? 1 : $clog2(WARMUP_TICKS + 1);
    localparam logic [WCW-1:0] WARM_MAX = WCW'(WARMUP_TICKS);
    localparam int SW = TW + 9;

    localparam logic signed [SW-1:0]  PWM_NEUTRAL_W = SW'(PWM_NEUTRAL);
    localparam logic signed [SW-1:0]  PWM_LOW_W     = SW'(PWM_LOW);
    localparam logic signed [SW-1:0]  PWM_HIGH_W    = SW'(PWM_HIGH);
    localparam logic [PWM_W-1:0]      PWM_NEUTRAL_O = PWM_W'(PWM_NEUTRAL);
    localparam logic [PWM_W-1:0]      PWM_LOW_O     = PWM_W'(PWM_LOW);
    localparam logic [PWM_W-1:0]      PWM_HIGH_O    = PWM_W'(PWM_HIGH);

    // Sequencer: clamp, three term products, one pass over both polynomials,
    // optional fallback check plus a second pass, then the two pulse widths.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLAMP = 7'b0000010,
        ST_TERMS = 7'b0000100,
        ST_POLY  = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_PWM   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                    state_reg,    state_next;
    logic [STEP_W-1:0]         step_reg,     step_next;
    logic                      op_vld_reg,   op_vld_next;
    logic                      check_reg,    check_next;
    logic [WCW-1:0]            warm_cnt_reg, warm_cnt_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // configuration
    logic signed [DATA_W-1:0]  cfg_smf_reg;
    logic signed [DATA_W-1:0]  cfg_sft_reg;
    logic signed [DATA_W-1:0]  cfg_smr_reg;
    logic signed [DATA_W-1:0]  cfg_yrt_reg;
    logic [YMAX_W-1:0]         cfg_ymax_reg;
    logic signed [DATA_W-1:0]  cfg_dzp_reg;
    logic signed [DATA_W-1:0]  cfg_dzn_reg;

    // working payload
    logic signed [DATA_W-1:0]  u_reg,        u_next;
    logic signed [DATA_W-1:0]  r_reg,        r_next;
    logic signed [MUL_W-1:0]   t_uu_reg,     t_uu_next;
    logic signed [MUL_W-1:0]   t_ur_reg,     t_ur_next;
    logic signed [MUL_W-1:0]   t_rr_reg,     t_rr_next;
    logic signed [ACC_W-1:0]   acc_m_reg,    acc_m_next;
    logic signed [ACC_W-1:0]   acc_d_reg,    acc_d_next;
    logic [ZONE_W-1:0]         zone_reg,     zone_next;
    logic signed [TW-1:0]      adj_reg,      adj_next;
    logic [PWM_W-1:0]          pwm_l_reg,    pwm_l_next;
    logic [PWM_W-1:0]          pwm_r_reg,    pwm_r_next;
    logic [2:0]                op_term_reg,  op_term_next;
    logic                      op_isd_reg,   op_isd_next;
    logic                      op_neg_reg,   op_neg_next;

    // output holding register
    logic [PWM_W-1:0]          o_pwm_l_reg,  o_pwm_l_next;
    logic [PWM_W-1:0]          o_pwm_r_reg,  o_pwm_r_next;
    logic [ZONE_W-1:0]         o_zone_reg,   o_zone_next;
    logic signed [DATA_W-1:0]  o_surge_reg,  o_surge_next;
    logic signed [DATA_W-1:0]  o_yaw_reg,    o_yaw_next;

    // ------------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------------
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [RND_W-1:0]   mul_res;
    logic signed [ACC_W-1:0]   mul_res_w;

    dta_mul_round u_mul (
        .aclk   (aclk),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .result (mul_res)
    );

    assign mul_res_w = {{(ACC_W-RND_W){mul_res[RND_W-1]}}, mul_res};

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    // Add the dead-zone offset (doubled, since commands are held at 2x).
    function automatic logic signed [TW-1:0] add_deadzone(input logic signed [TW-1:0] x,
                                                          input logic signed [DATA_W-1:0] dzp,
                                                          input logic signed [DATA_W-1:0] dzn);
        logic signed [TW-1:0] dzp2;
        logic signed [TW-1:0] dzn2;
        logic signed [TW-1:0] res;
        dzp2 = {{(TW-DATA_W-1){dzp[DATA_W-1]}}, dzp, 1'b0};
        dzn2 = {{(TW-DATA_W-1){dzn[DATA_W-1]}}, dzn, 1'b0};
        res  = x;
        if (x > 0) begin
            res = x + dzp2;
        end else if (x < 0) begin
            res = x + dzn2;
        end
        return res;
    endfunction

    // 1500 + floor(400 * x / 2^(F+1)), saturated; 400x built as 256x + 128x + 16x.
    function automatic logic [PWM_W-1:0] pwm_scale(input logic signed [TW-1:0] x);
        logic signed [SW-1:0] xw;
        logic signed [SW-1:0] p400;
        logic signed [SW-1:0] v;
        logic [PWM_W-1:0]     res;
        xw   = {{(SW-TW){x[TW-1]}}, x};
        p400 = (xw <<< 8) + (xw <<< 7) + (xw <<< 4);
        v    = (p400 >>> (FRAC_BITS + 1)) + PWM_NEUTRAL_W;
        if (v < PWM_LOW_W) begin
            res = PWM_LOW_O;
        end else if (v > PWM_HIGH_W) begin
            res = PWM_HIGH_O;
        end else begin
            res = v[PWM_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clamp and zone selection
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0]  u_hi, u_cl, r_cl;
    logic signed [DATA_W:0]    r_w, ymax_w, r_cl_w, yrt_w;
    logic [ZONE_W-1:0]         zone_pick;
    logic                      check_pick;

    always_comb begin
        // upper clamp first, lower second: crossed limits land on the lower one
        u_hi   = (u_reg > cfg_smf_reg) ? cfg_smf_reg : u_reg;
        u_cl   = (u_hi < cfg_smr_reg) ? cfg_smr_reg : u_hi;
        r_w    = {r_reg[DATA_W-1], r_reg};
        ymax_w = {2'b00, cfg_ymax_reg};
        if (r_w > ymax_w) begin
            r_cl_w = ymax_w;
        end else if (r_w < -ymax_w) begin
            r_cl_w = -ymax_w;
        end else begin
            r_cl_w = r_w;
        end
        r_cl = r_cl_w[DATA_W-1:0];

        // pick the zone from the clamped demands
        yrt_w      = {cfg_yrt_reg[DATA_W-1], cfg_yrt_reg};
        check_pick = 1'b0;
        if (u_reg > cfg_sft_reg) begin
            zone_pick = ZONE_FWD;
        end else if (r_w > yrt_w) begin
            zone_pick = ZONE_REV;
        end else if (r_w < -yrt_w) begin
            zone_pick = ZONE_MIR;
        end else begin
            zone_pick  = ZONE_FWD;
            check_pick = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Polynomial op decode
    // ------------------------------------------------------------------------
    logic                      iss_isd;
    logic [2:0]                iss_term;
    logic signed [MUL_W-1:0]   iss_val;
    logic                      iss_neg;
    logic signed [MUL_W-1:0]   u_ext, r_ext;

    assign u_ext = {{(MUL_W-DATA_W){u_reg[DATA_W-1]}}, u_reg};
    assign r_ext = {{(MUL_W-DATA_W){r_reg[DATA_W-1]}}, r_reg};

    always_comb begin
        // steps 0..4 walk m over u..r*r, steps 5..9 walk d
        iss_isd  = (step_reg >= 4'd5);
        iss_term = iss_isd ? 3'(step_reg - 4'd4) : 3'(step_reg + 4'd1);
        case (iss_term)
            TERM_U:  iss_val = u_ext;
            TERM_R:  iss_val = r_ext;
            TERM_UU: iss_val = t_uu_reg;
            TERM_UR: iss_val = t_ur_reg;
            TERM_RR: iss_val = t_rr_reg;
            default: iss_val = '0;
        endcase
        // mirrored zone folds the yaw sign into the reverse model
        if (zone_reg == ZONE_MIR) begin
            if (iss_isd) begin
                iss_neg = (iss_term == TERM_U) || (iss_term == TERM_UU) || (iss_term == TERM_RR);
            end else begin
                iss_neg = (iss_term == TERM_R) || (iss_term == TERM_UR);
            end
        end else begin
            iss_neg = 1'b0;
        end
    end

    // commands at twice their value
    logic signed [TW-1:0]      m2_w, d_w, twice_l, twice_r;
    logic                      fallback;

    always_comb begin
        m2_w     = {acc_m_reg[ACC_W-1], acc_m_reg, 1'b0};
        d_w      = {{2{acc_d_reg[ACC_W-1]}}, acc_d_reg};
        twice_l  = m2_w + d_w;
        twice_r  = m2_w - d_w;
        fallback = (m2_w <= d_w) || (m2_w <= -d_w);
    end

    logic                      s_accept;
    assign s_tready = state_reg == ST_IDLE;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        op_vld_next   = 1'b0;
        check_next    = check_reg;
        warm_cnt_next = warm_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        u_next        = u_reg;
        r_next        = r_reg;
        t_uu_next     = t_uu_reg;
        t_ur_next     = t_ur_reg;
        t_rr_next     = t_rr_reg;
        acc_m_next    = acc_m_reg;
        acc_d_next    = acc_d_reg;
        zone_next     = zone_reg;
        adj_next      = adj_reg;
        pwm_l_next    = pwm_l_reg;
        pwm_r_next    = pwm_r_reg;
        op_term_next  = op_term_reg;
        op_isd_next   = op_isd_reg;
        op_neg_next   = op_neg_reg;
        o_pwm_l_next  = o_pwm_l_reg;
        o_pwm_r_next  = o_pwm_r_reg;
        o_zone_next   = o_zone_reg;
        o_surge_next  = o_surge_reg;
        o_yaw_next    = o_yaw_reg;
        mul_a         = '0;
        mul_b         = '0;

        // drop valid once the beat is taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // retire the product issued last cycle
        if (op_vld_reg) begin
            if (state_reg == ST_TERMS) begin
                case (op_term_reg)
                    TERM_UU: t_uu_next = mul_res[MUL_W-1:0];
                    TERM_UR: t_ur_next = mul_res[MUL_W-1:0];
                    TERM_RR: t_rr_next = mul_res[MUL_W-1:0];
                    default: ;
                endcase
            end else if (state_reg == ST_POLY) begin
                if (op_isd_reg) begin
                    acc_d_next = op_neg_reg ? acc_d_reg - mul_res_w : acc_d_reg + mul_res_w;
                end else begin
                    acc_m_next = op_neg_reg ? acc_m_reg - mul_res_w : acc_m_reg + mul_res_w;
                end
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!s_tuser[0]) begin
                        // disarmed: no beat out, restart warm-up
                        warm_cnt_next = '0;
                    end else if (warm_cnt_reg < WARM_MAX) begin
                        warm_cnt_next = warm_cnt_reg + WCW'(1);
                        u_next        = '0;
                        r_next        = '0;
                        zone_next     = ZONE_FWD;
                        pwm_l_next    = PWM_NEUTRAL_O;
                        pwm_r_next    = PWM_NEUTRAL_O;
                        state_next    = ST_OUT;
                    end else begin
                        u_next     = s_tdata[DATA_W-1:0];
                        r_next     = s_tdata[2*DATA_W-1:DATA_W];
                        state_next = ST_CLAMP;
                    end
                end
            end
            ST_CLAMP: begin
                u_next     = u_cl;
                r_next     = r_cl;
                step_next  = '0;
                state_next = ST_TERMS;
            end
            ST_TERMS: begin
                if (step_reg < N_TERM_OPS) begin
                    case (step_reg[1:0])
                        2'd0: begin
                            mul_a        = u_ext;
                            mul_b        = u_ext;
                            op_term_next = TERM_UU;
                        end
                        2'd1: begin
                            mul_a        = u_ext;
                            mul_b        = r_ext;
                            op_term_next = TERM_UR;
                        end
                        default: begin
                            mul_a        = r_ext;
                            mul_b        = r_ext;
                            op_term_next = TERM_RR;
                        end
                    endcase
                    op_vld_next = 1'b1;
                    step_next   = step_reg + 4'd1;
                end else begin
                    // seed both sums with the constant coefficient
                    zone_next  = zone_pick;
                    check_next = check_pick;
                    acc_m_next = ACC_W'(coef_q(zone_pick != ZONE_FWD, 1'b0, TERM_ONE));
                    acc_d_next = ACC_W'(coef_q(zone_pick != ZONE_FWD, 1'b1, TERM_ONE));
                    step_next  = '0;
                    state_next = ST_POLY;
                end
            end
            ST_POLY: begin
                if (step_reg < N_POLY_OPS) begin
                    mul_a        = coef_q(zone_reg != ZONE_FWD, iss_isd, iss_term);
                    mul_b        = iss_val;
                    op_term_next = iss_term;
                    op_isd_next  = iss_isd;
                    op_neg_next  = iss_neg;
                    op_vld_next  = 1'b1;
                    step_next    = step_reg + 4'd1;
                end else begin
                    step_next  = '0;
                    state_next = check_reg ? ST_CHECK : ST_PWM;
                end
            end
            ST_CHECK: begin
                check_next = 1'b0;
                if (fallback) begin
                    // forward model cannot deliver: rerun with a reverse model
                    zone_next  = r_reg[DATA_W-1] ? ZONE_MIR : ZONE_REV;
                    acc_m_next = ACC_W'(coef_q(1'b1, 1'b0, TERM_ONE));
                    acc_d_next = ACC_W'(coef_q(1'b1, 1'b1, TERM_ONE));
                    step_next  = '0;
                    state_next = ST_POLY;
                end else begin
                    state_next = ST_PWM;
                end
            end
            ST_PWM: begin
                case (step_reg[1:0])
                    2'd0: begin
                        adj_next  = add_deadzone(twice_l, cfg_dzp_reg, cfg_dzn_reg);
                        step_next = step_reg + 4'd1;
                    end
                    2'd1: begin
                        pwm_l_next = pwm_scale(adj_reg);
                        adj_next   = add_deadzone(twice_r, cfg_dzp_reg, cfg_dzn_reg);
                        step_next  = step_reg + 4'd1;
                    end
                    default: begin
                        pwm_r_next = pwm_scale(adj_reg);
                        step_next  = '0;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    o_pwm_l_next  = pwm_l_reg;
                    o_pwm_r_next  = pwm_r_reg;
                    o_zone_next   = zone_reg;
                    o_surge_next  = u_reg;
                    o_yaw_next    = r_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            op_vld_reg   <= 1'b0;
            check_reg    <= 1'b0;
            warm_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
            cfg_smf_reg  <= RST_SURGE_MAX_FWD;
            cfg_sft_reg  <= RST_SURGE_FWD_THR;
            cfg_smr_reg  <= RST_SURGE_MIN_REV;
            cfg_yrt_reg  <= RST_YAW_REV_THR;
            cfg_ymax_reg <= RST_YAW_MAX_ABS;
            cfg_dzp_reg  <= RST_DZ_POS;
            cfg_dzn_reg  <= RST_DZ_NEG;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            op_vld_reg   <= op_vld_next;
            check_reg    <= check_next;
            warm_cnt_reg <= warm_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SURGE_MAX_FWD: cfg_smf_reg  <= cfg_wdata;
                    CFG_SURGE_FWD_THR: cfg_sft_reg  <= cfg_wdata;
                    CFG_SURGE_MIN_REV: cfg_smr_reg  <= cfg_wdata;
                    CFG_YAW_REV_THR:   cfg_yrt_reg  <= cfg_wdata;
                    CFG_YAW_MAX_ABS:   cfg_ymax_reg <= cfg_wdata[YMAX_W-1:0];
                    CFG_DZ_POS:        cfg_dzp_reg  <= cfg_wdata;
                    CFG_DZ_NEG:        cfg_dzn_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        u_reg       <= u_next;
        r_reg       <= r_next;
        t_uu_reg    <= t_uu_next;
        t_ur_reg    <= t_ur_next;
        t_rr_reg    <= t_rr_next;
        acc_m_reg   <= acc_m_next;
        acc_d_reg   <= acc_d_next;
        zone_reg    <= zone_next;
        adj_reg     <= adj_next;
        pwm_l_reg   <= pwm_l_next;
        pwm_r_reg   <= pwm_r_next;
        op_term_reg <= op_term_next;
        op_isd_reg  <= op_isd_next;
        op_neg_reg  <= op_neg_next;
        o_pwm_l_reg <= o_pwm_l_next;
        o_pwm_r_reg <= o_pwm_r_next;
        o_zone_reg  <= o_zone_next;
        o_surge_reg <= o_surge_next;
        o_yaw_reg   <= o_yaw_next;
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, o_yaw_reg, o_surge_reg, o_pwm_r_reg, o_pwm_l_reg};
    assign m_tuser  = o_zone_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DTA_ASSERT_NXT(a_disarm_clears_warmup, s_accept && !s_tuser[0], warm_cnt_reg == '0,
        "disarmed beat did not clear the warm-up count")
    `DTA_ASSERT_NXT(a_armed_beat_blocks_input, s_accept && s_tuser[0], !s_tready,
        "armed beat accepted while another tick is in flight")
    `DTA_ASSERT_IMP(a_warmup_bounded, 1'b1, warm_cnt_reg <= WARM_MAX,
        "warm-up count ran past its limit")
    `DTA_ASSERT_IMP(a_pwm_in_range, m_tvalid,
        (m_tdata[10:0] >= PWM_LOW_O) && (m_tdata[10:0] <= PWM_HIGH_O) &&
        (m_tdata[21:11] >= PWM_LOW_O) && (m_tdata[21:11] <= PWM_HIGH_O),
        "pulse width outside the saturation band")
    `DTA_ASSERT_IMP(a_zone_legal, m_tvalid,
        (m_tuser == ZONE_FWD) || (m_tuser == ZONE_REV) || (m_tuser == ZONE_MIR),
        "zone code out of range")

endmodule
